[design/rsk_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsk_pkg
// Shared types and widths for the record sorter: record layout held in each
// cell of the chain and the control word broadcast along it.
// ----------------------------------------------------------------------------
package rsk_pkg;

  localparam int KEY_W = 16;
  localparam int TAG_W = 8;

  // One stored record with its occupancy bit
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rec_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic insert;  // place the incoming item into the sorted chain
    logic shift;   // move every record one cell towards the head
  } ctrl_t;

endpackage
`default_nettype wire

[design/rsk_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsk_in_if
// Input channel of the record sorter: one record per item, valid/ready.
// ----------------------------------------------------------------------------
interface rsk_in_if;
  logic                    valid;
  logic                    ready;
  logic [rsk_pkg::KEY_W-1:0] sort_key;
  logic [rsk_pkg::TAG_W-1:0] record_tag;
  logic                    last_in_set;

  modport source (output valid, output sort_key, output record_tag,
                  output last_in_set, input ready);
  modport sink   (input valid, input sort_key, input record_tag,
                  input last_in_set, output ready);
endinterface
`default_nettype wire

[design/rsk_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsk_out_if
// Result channel of the record sorter: one sorted record per item.
// ----------------------------------------------------------------------------
interface rsk_out_if;
  logic                    valid;
  logic                    ready;
  logic [rsk_pkg::KEY_W-1:0] sorted_key;
  logic [rsk_pkg::TAG_W-1:0] sorted_tag;
  logic                    final_result;
  logic                    records_dropped;

  modport source (output valid, output sorted_key, output sorted_tag,
                  output final_result, output records_dropped, input ready);
  modport sink   (input valid, input sorted_key, input sorted_tag,
                  input final_result, input records_dropped, output ready);
endinterface
`default_nettype wire

[design/rsk_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsk_cell
// One cell of the insertion chain. Holds one record. On insert, a cell whose
// key is greater than the new key (or the first empty cell) takes either its
// left neighbour's record or the new one; on shift it takes its right one.
// ----------------------------------------------------------------------------
module rsk_cell (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire rsk_pkg::ctrl_t        ctrl,
  input  wire [rsk_pkg::KEY_W-1:0]   ins_key,
  input  wire [rsk_pkg::TAG_W-1:0]   ins_tag,
  input  wire rsk_pkg::rec_t         prev_rec,
  input  wire                        prev_gt,
  input  wire rsk_pkg::rec_t         next_rec,
  output rsk_pkg::rec_t              rec,
  output logic                       gt
);

  rsk_pkg::rec_t rec_r;
  rsk_pkg::rec_t rec_nxt;
  logic          load;

  assign rec = rec_r;

  // Stored key is strictly greater: equal keys stay ahead of the new item
  assign gt = rec_r.valid && (rec_r.key > ins_key);

  // Take part in an insert when displaced or when first empty cell
  assign load = ctrl.insert && (gt || (!rec_r.valid && prev_rec.valid));

  // Select next content
  always_comb begin
    rec_nxt = rec_r;
    if (ctrl.shift) begin
      rec_nxt = next_rec;
    end else if (load) begin
      if (prev_gt) begin
        rec_nxt = prev_rec;
      end else begin
        rec_nxt.valid = 1'b1;
        rec_nxt.key   = ins_key;
        rec_nxt.tag   = ins_tag;
      end
    end
  end

  // Occupancy bit under reset, payload without
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.valid <= 1'b0;
    end else begin
      rec_r.valid <= rec_nxt.valid;
    end
    rec_r.key <= rec_nxt.key;
    rec_r.tag <= rec_nxt.tag;
  end

endmodule
`default_nettype wire

[design/record_sort_by_key_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// record_sort_by_key_top
// Stable sorter for key/tag records built as a chain of insertion cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one record per item (sort_key, record_tag, last_in_set).
//              Each accepted item is placed into the sorted chain in the same
//              cycle unless full, so loading runs at one item per cycle.
//   out_chan : after an item with last_in_set, the stored records leave in
//              ascending key order, equal keys in arrival order, one item per
//              cycle from the head cell; final_result marks the last one.
//   Unload   : the first result is valid in the cycle after the last item is
//              accepted; in_ready is low while unloading.
//   Overflow : items arriving with all MAX_RECORDS cells full are dropped and
//              records_dropped is high on every result of that set.
//   Stall    : with out_ready low the chain holds and the head record waits.
//   Reset    : rst_n (synchronous, active low) empties the chain and clears
//              the overflow flag; the block then accepts items.
// ----------------------------------------------------------------------------
module record_sort_by_key_top #(
  parameter int MAX_RECORDS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  rsk_in_if.sink      in_chan,
  rsk_out_if.source   out_chan
);

  rsk_pkg::rec_t  cell_rec [MAX_RECORDS];
  logic           cell_gt  [MAX_RECORDS];
  rsk_pkg::ctrl_t ctrl;

  logic draining_r;
  logic draining_nxt;
  logic ovf_r;
  logic ovf_nxt;
  logic in_fire;
  logic out_fire;
  logic full;
  logic tail_last;

  assign full      = cell_rec[MAX_RECORDS-1].valid;
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign out_fire  = out_chan.valid && out_chan.ready;
  assign tail_last = !cell_rec[1].valid;

  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = out_fire;

  // Cell chain
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    rsk_pkg::rec_t prev_rec;
    rsk_pkg::rec_t next_rec;
    logic          prev_gt;

    if (i == 0) begin : g_head
      assign prev_rec = '{valid: 1'b1, key: '0, tag: '0};
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_rec = cell_rec[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign next_rec = '{valid: 1'b0, key: '0, tag: '0};
    end else begin : g_mid
      assign next_rec = cell_rec[i+1];
    end

    rsk_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .ins_key  (in_chan.sort_key),
      .ins_tag  (in_chan.record_tag),
      .prev_rec (prev_rec),
      .prev_gt  (prev_gt),
      .next_rec (next_rec),
      .rec      (cell_rec[i]),
      .gt       (cell_gt[i])
    );
  end

  // Load / unload sequencing and overflow flag
  always_comb begin
    draining_nxt = draining_r;
    ovf_nxt      = ovf_r;
    if (in_fire) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end
      if (in_chan.last_in_set) begin
        draining_nxt = 1'b1;
      end
    end
    if (out_fire && tail_last) begin
      draining_nxt = 1'b0;
      ovf_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      draining_r <= draining_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // Channel outputs
  assign in_chan.ready            = !draining_r;
  assign out_chan.valid           = draining_r;
  assign out_chan.sorted_key      = cell_rec[0].key;
  assign out_chan.sorted_tag      = cell_rec[0].tag;
  assign out_chan.final_result    = tail_last;
  assign out_chan.records_dropped = ovf_r;

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key/tag record sorter. A fixed table of short
// sets exercises the key and tag extremes, reverse and in-order arrival and
// runs of equal keys. Random sets follow, mostly small, plus one set that
// fills the store and overflows it. Every accepted record feeds a stable
// insertion model. Each emitted record is checked in order against it, while
// both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STORE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 100;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SHOWN_ERRORS = 10;

  // One emitted record as it should leave the sorter
  typedef struct packed {
    logic [rsk_pkg::KEY_W-1:0] key;
    logic [rsk_pkg::TAG_W-1:0] tag;
    logic                      fin;
    logic                      drop;
  } sorted_rec_t;

  // One record held in the model's ordered store
  typedef struct packed {
    logic [rsk_pkg::KEY_W-1:0] key;
    logic [rsk_pkg::TAG_W-1:0] tag;
  } held_rec_t;

  // Directed stimulus: typed outcome only for single-record sets
  typedef struct {
    logic [rsk_pkg::KEY_W-1:0] key;
    logic [rsk_pkg::TAG_W-1:0] tag;
    logic                      last;
    bit                        typed;
    sorted_rec_t               want;
  } warmup_row_t;

  localparam int WARMUP_ROWS = 18;

  warmup_row_t warmup_table [WARMUP_ROWS] = '{
    // lone record, smallest key and tag
    '{16'h0000, 8'h00, 1'b1, 1'b1, '{16'h0000, 8'h00, 1'b1, 1'b0}},
    // lone record, largest key and tag
    '{16'hFFFF, 8'hFF, 1'b1, 1'b1, '{16'hFFFF, 8'hFF, 1'b1, 1'b0}},
    // reverse order arrival
    '{16'hFFFF, 8'h01, 1'b0, 1'b0, '0},
    '{16'h8000, 8'h02, 1'b0, 1'b0, '0},
    '{16'h0001, 8'h03, 1'b0, 1'b0, '0},
    '{16'h0000, 8'h04, 1'b1, 1'b0, '0},
    // equal keys must keep arrival order
    '{16'h0042, 8'hA0, 1'b0, 1'b0, '0},
    '{16'h0042, 8'hA1, 1'b0, 1'b0, '0},
    '{16'h0010, 8'hA2, 1'b0, 1'b0, '0},
    '{16'h0042, 8'hA3, 1'b0, 1'b0, '0},
    '{16'h0042, 8'hA4, 1'b1, 1'b0, '0},
    // already ascending, duplicated extremes
    '{16'h0000, 8'h10, 1'b0, 1'b0, '0},
    '{16'h0000, 8'h11, 1'b0, 1'b0, '0},
    '{16'h7FFF, 8'h12, 1'b0, 1'b0, '0},
    '{16'hFFFF, 8'h13, 1'b0, 1'b0, '0},
    '{16'hFFFF, 8'h14, 1'b1, 1'b0, '0},
    // alternating bit patterns
    '{16'h5555, 8'hAA, 1'b1, 1'b1, '{16'h5555, 8'hAA, 1'b1, 1'b0}},
    '{16'hAAAA, 8'h55, 1'b1, 1'b1, '{16'hAAAA, 8'h55, 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  rsk_in_if  in_ch ();
  rsk_out_if out_ch ();

  record_sort_by_key_top #(
    .MAX_RECORDS (STORE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  held_rec_t   ordered_store[$];
  bit          store_overflowed;
  sorted_rec_t sorted_due[$];
  int          mismatch_count;
  int          cycle_count;
  bit          calm;
  bit          gaps_on;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stable insertion: a record goes after every stored key not above its own
  function automatic void absorb_record(input logic [rsk_pkg::KEY_W-1:0] k,
                                        input logic [rsk_pkg::TAG_W-1:0] t,
                                        input logic l, input bit book);
    int          pos;
    held_rec_t   rec;
    sorted_rec_t res;
    if (ordered_store.size() >= STORE_DEPTH) begin
      store_overflowed = 1'b1;
    end else begin
      pos = ordered_store.size();
      while (pos > 0 && ordered_store[pos-1].key > k) pos--;
      rec.key = k;
      rec.tag = t;
      ordered_store.insert(pos, rec);
    end
    if (l) begin
      if (book) begin
        foreach (ordered_store[i]) begin
          res.key  = ordered_store[i].key;
          res.tag  = ordered_store[i].tag;
          res.fin  = (i == ordered_store.size() - 1);
          res.drop = store_overflowed;
          sorted_due.push_back(res);
        end
      end
      ordered_store.delete();
      store_overflowed = 1'b0;
    end
  endfunction

  // Offer one record, with an optional gap first, and book it once taken
  task automatic push_record(input logic [rsk_pkg::KEY_W-1:0] k,
                             input logic [rsk_pkg::TAG_W-1:0] t,
                             input logic l, input bit book);
    if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sort_key    <= k;
    in_ch.record_tag  <= t;
    in_ch.last_in_set <= l;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    absorb_record(k, t, l, book);
  endtask

  // Hold the input until every booked result has left
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sorted_due.size() != 0);
  endtask

  // Mix of duplicate-heavy, extreme and full-range keys
  function automatic logic [rsk_pkg::KEY_W-1:0] pick_key();
    unique case ($urandom_range(0, 3))
      0:       return rsk_pkg::KEY_W'($urandom_range(0, 7));
      1:       return $urandom_range(0, 1) ? {rsk_pkg::KEY_W{1'b1}} : {rsk_pkg::KEY_W{1'b0}};
      default: return rsk_pkg::KEY_W'($urandom());
    endcase
  endfunction

  task automatic send_random_set(input int n);
    gaps_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n; i++) begin
      push_record(pick_key(), rsk_pkg::TAG_W'($urandom_range(0, 255)), i == n - 1, 1'b1);
    end
  endtask

  task automatic flag_mismatch(input string why, input sorted_rec_t want,
                               input sorted_rec_t seen);
    mismatch_count++;
    if (mismatch_count <= SHOWN_ERRORS) begin
      $display("%s: expected key=%h tag=%h fin=%b drop=%b, got key=%h tag=%h fin=%b drop=%b",
               why, want.key, want.tag, want.fin, want.drop,
               seen.key, seen.tag, seen.fin, seen.drop);
    end
  endtask

  // Stall the result side in bursts, none once the run turns calm
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each taken result with the oldest booked one
  always @(posedge clk) begin : result_check
    sorted_rec_t seen;
    sorted_rec_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.key  = out_ch.sorted_key;
      seen.tag  = out_ch.sorted_tag;
      seen.fin  = out_ch.final_result;
      seen.drop = out_ch.records_dropped;
      if (sorted_due.size() == 0) begin
        flag_mismatch("result with nothing booked", '0, seen);
      end else begin
        want = sorted_due.pop_front();
        if (seen.key !== want.key || seen.tag !== want.tag ||
            seen.fin !== want.fin || seen.drop !== want.drop) begin
          flag_mismatch("result mismatch", want, seen);
        end
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[record_sort_by_key_top] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int done_items;
    int set_len;
    bit big_sets_done;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.sort_key    = '0;
    in_ch.record_tag  = '0;
    in_ch.last_in_set = 1'b0;
    mismatch_count    = 0;
    cycle_count       = 0;
    calm              = 1'b0;
    gaps_on           = 1'b1;
    store_overflowed  = 1'b0;
    done_items        = 0;
    big_sets_done     = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (warmup_table[i]) begin
      push_record(warmup_table[i].key, warmup_table[i].tag, warmup_table[i].last,
                  !warmup_table[i].typed);
      if (warmup_table[i].typed) sorted_due.push_back(warmup_table[i].want);
    end
    hold_until_drained();

    // Random sets; one that fills the store and overflows it partway through
    while (done_items < RANDOM_ITEMS) begin
      if (done_items >= 15 && !big_sets_done) begin
        send_random_set(STORE_DEPTH + 1);
        done_items += STORE_DEPTH + 1;
        big_sets_done = 1'b1;
      end
      if (done_items >= RANDOM_ITEMS * 4 / 5) calm = 1'b1;
      set_len = $urandom_range(1, 8);
      send_random_set(set_len);
      done_items += set_len;
    end

    in_ch.valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && sorted_due.size() == 0) begin
      $display("[record_sort_by_key_top] OK");
    end else begin
      $display("[record_sort_by_key_top] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
